FILE: design/sorted_priority_queue_top_defines.svh
// Assertion macros used by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted priority queue: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted priority queue: next-cycle check failed");

`endif

FILE: design/spq_pkg.sv
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int DATA_BITS = 32;
  localparam int PRIORITY_BITS = 8;

  typedef enum logic [1:0] {
    CMD_ENQ         = 2'd0,
    CMD_DEQ_HEAD    = 2'd1,
    CMD_DEQ_EXACT   = 2'd2,
    CMD_DEQ_AT_MOST = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t                          command;
    logic signed [DATA_BITS-1:0]   data;
    logic [PRIORITY_BITS-1:0]      priority_req;
  } req_t;

  typedef struct packed {
    status_t                       status;
    logic signed [DATA_BITS-1:0]   out_data;
    logic [PRIORITY_BITS-1:0]      out_priority;
  } rsp_t;

  // Contents of one cell.
  typedef struct packed {
    logic                          valid;
    logic signed [DATA_BITS-1:0]   data;
    logic [PRIORITY_BITS-1:0]      prio;
  } entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic                          go;
    cmd_t                          cmd;
    logic signed [DATA_BITS-1:0]   data;
    logic [PRIORITY_BITS-1:0]      pr;
    logic                          full;
    logic                          found;
  } op_t;

endpackage

FILE: design/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: a chain of DEPTH cells and a result register.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  spq_pkg::req_t (command, data, priority_req)
//   rsp      out        rsp_valid/rsp_ready  spq_pkg::rsp_t (status, out_data, out_priority)
//
// Every command completes in the cycle of its transfer; its result is registered and appears on rsp in the next cycle.
// One command per cycle is sustained while rsp is taken; the single result register sets this.
// req_ready is low only while a result waits in that register and rsp_ready is low.
// Synchronous reset empties the chain; entry payloads are not cleared.
module sorted_priority_queue_top #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  spq_pkg::entry_t cell_q [DEPTH];
  logic [DEPTH-1:0] hit;
  spq_pkg::op_t     op;
  spq_pkg::rsp_t    rsp_next;
  logic signed [spq_pkg::DATA_BITS-1:0] sel_data;
  logic [spq_pkg::PRIORITY_BITS-1:0]    sel_prio;
  logic             accept;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  assign op.go    = accept;
  assign op.cmd   = req.command;
  assign op.data  = req.data;
  assign op.pr    = req.priority_req;
  assign op.full  = cell_q[DEPTH-1].valid;
  assign op.found = |hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left;
    spq_pkg::entry_t right;
    if (i == 0) begin : g_head
      assign left = '0;
    end else begin : g_mid
      assign left = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = '0;
    end else begin : g_body
      assign right = cell_q[i+1];
    end
    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .head  (i == 0),
      .op    (op),
      .left  (left),
      .right (right),
      .q     (cell_q[i]),
      .hit   (hit[i])
    );
  end

  // At most one cell hits, so an AND-OR select picks the removed entry.
  always_comb begin
    sel_data = '0;
    sel_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_data = sel_data | (cell_q[i].data & {spq_pkg::DATA_BITS{hit[i]}});
      sel_prio = sel_prio | (cell_q[i].prio & {spq_pkg::PRIORITY_BITS{hit[i]}});
    end
  end

  always_comb begin
    rsp_next.out_data     = '0;
    rsp_next.out_priority = '0;
    if (req.command == spq_pkg::CMD_ENQ) begin
      rsp_next.status = op.full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
    end else if (op.found) begin
      rsp_next.status       = spq_pkg::ST_OK;
      rsp_next.out_data     = sel_data;
      rsp_next.out_priority = sel_prio;
    end else begin
      rsp_next.status = spq_pkg::ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: design/spq_cell.sv
// One cell of the sorted chain: holds an entry and trades it with its neighbors.
module spq_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           head,
  input  spq_pkg::op_t   op,
  input  spq_pkg::entry_t left,
  input  spq_pkg::entry_t right,
  output spq_pkg::entry_t q,
  output logic           hit
);

  spq_pkg::entry_t q_next;
  logic keep_le;
  logic left_le;
  logic shift;

  assign keep_le = q.valid && (q.prio <= op.pr);
  assign left_le = left.valid && (left.prio <= op.pr);
  // Entries at or behind the removed one move one place toward the head.
  assign shift   = (op.cmd != spq_pkg::CMD_DEQ_EXACT) || !q.valid || (q.prio >= op.pr);

  always_comb begin
    case (op.cmd)
      spq_pkg::CMD_DEQ_HEAD:    hit = head && q.valid;
      spq_pkg::CMD_DEQ_AT_MOST: hit = head && keep_le;
      spq_pkg::CMD_DEQ_EXACT:   hit = q.valid && (q.prio == op.pr) &&
                                      (head || (left.prio < op.pr));
      default:                  hit = 1'b0;
    endcase
  end

  always_comb begin
    q_next = q;
    if (op.go) begin
      if (op.cmd == spq_pkg::CMD_ENQ) begin
        if (!op.full && !keep_le) begin
          if (head || left_le) begin
            q_next.valid = 1'b1;
            q_next.data  = op.data;
            q_next.prio  = op.pr;
          end else begin
            q_next = left;
          end
        end
      end else if (op.found && shift) begin
        q_next = right;
      end
    end
  end

  // Only the valid bit is reset; the payload is don't-care while the cell is empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else begin
      q.valid <= q_next.valid;
    end
    q.data <= q_next.data;
    q.prio <= q_next.prio;
  end

endmodule

FILE: design/spq_checker.sv
// Port-level checks of the sorted priority queue, bound to its top level.
`include "sorted_priority_queue_top_defines.svh"

module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input spq_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input spq_pkg::rsp_t rsp
);

  `SPQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
  `SPQ_ASSERT_NEXT(a_result_follows, clk, rst, req_valid && req_ready, rsp_valid)
  `SPQ_ASSERT_NOW(a_ready_when_free, clk, rst, !rsp_valid, req_ready)
  `SPQ_ASSERT_NOW(a_zero_on_miss, clk, rst, rsp_valid && (rsp.status != spq_pkg::ST_OK), (rsp.out_data == 0) && (rsp.out_priority == 0))

endmodule

bind sorted_priority_queue_top spq_checker u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

FILE: tb/testbench.sv
// Self-checking testbench for the sorted priority queue: directed and random commands.
`timescale 1ns / 1ps

module testbench;

  localparam int QUEUE_DEPTH = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 400;

  typedef logic [spq_pkg::PRIORITY_BITS-1:0]    prio_t;
  typedef logic signed [spq_pkg::DATA_BITS-1:0] word_t;

  // Tracks the queue contents and the results still owed by the block.
  class spq_scoreboard;
    word_t                       held_data [QUEUE_DEPTH];
    prio_t                       held_prio [QUEUE_DEPTH];
    int                          held_count;
    spq_pkg::rsp_t               expected_results [$];
    int                          mismatches;

    function new();
      held_count = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // A priority that is currently stored (random when the queue is empty), so that exact matches hit often.
    function prio_t stored_priority();
      if (held_count == 0) begin
        return prio_t'($urandom);
      end
      return held_prio[$urandom_range(held_count - 1)];
    endfunction

    function spq_pkg::rsp_t predict_result(spq_pkg::req_t r);
      spq_pkg::rsp_t res;
      int   pos;
      int   hit;
      res.status = spq_pkg::ST_NONE;
      res.out_data = '0;
      res.out_priority = '0;
      if (r.command == spq_pkg::CMD_ENQ) begin
        if (held_count >= QUEUE_DEPTH) begin
          res.status = spq_pkg::ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_prio[pos] <= r.priority_req) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_data[i] = held_data[i - 1];
            held_prio[i] = held_prio[i - 1];
          end
          held_data[pos] = r.data;
          held_prio[pos] = r.priority_req;
          held_count++;
          res.status = spq_pkg::ST_OK;
        end
      end else begin
        hit = -1;
        for (int i = 0; i < held_count && hit < 0; i++) begin
          case (r.command)
            spq_pkg::CMD_DEQ_HEAD: hit = i;
            spq_pkg::CMD_DEQ_EXACT: if (held_prio[i] == r.priority_req) hit = i;
            default: if (held_prio[i] <= r.priority_req) hit = i;
          endcase
        end
        if (hit >= 0) begin
          res.status = spq_pkg::ST_OK;
          res.out_data = held_data[hit];
          res.out_priority = held_prio[hit];
          for (int i = hit; i + 1 < held_count; i++) begin
            held_data[i] = held_data[i + 1];
            held_prio[i] = held_prio[i + 1];
          end
          held_count--;
        end
      end
      return res;
    endfunction

    function void note_command(spq_pkg::req_t r);
      expected_results.push_back(predict_result(r));
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endfunction

    function void check_result(spq_pkg::rsp_t got);
      spq_pkg::rsp_t want;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result status=%0d data=%h prio=%h",
                       got.status, got.out_data, got.out_priority));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) begin
        flag($sformatf("status expected %0d got %0d", want.status, got.status));
      end
      if (got.out_data !== want.out_data) begin
        flag($sformatf("out_data expected %h got %h", want.out_data, got.out_data));
      end
      if (got.out_priority !== want.out_priority) begin
        flag($sformatf("out_priority expected %h got %h", want.out_priority,
                       got.out_priority));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  spq_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b1;
  spq_pkg::rsp_t rsp;

  spq_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;

  sorted_priority_queue_top #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("testbench NOT OK");
    $finish;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        rsp_ready <= 1'b1;
      end else if (hold_left > 0) begin
        rsp_ready <= 1'b0;
        hold_left--;
      end else if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
      if (req_valid && req_ready) sb.note_command(req);
    end
  end

  function spq_pkg::req_t make_cmd(spq_pkg::cmd_t c, word_t d, prio_t p);
    spq_pkg::req_t r;
    r.command = c;
    r.data = d;
    r.priority_req = p;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_command(spq_pkg::req_t r);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_ready !== 1'b1);
    @(negedge clk);
  endtask

  function spq_pkg::req_t random_command(int enq_pct);
    spq_pkg::req_t r;
    int   pick;
    r.data = $urandom;
    pick = $urandom_range(9);
    if (pick < 4) r.priority_req = prio_t'($urandom);
    else if (pick < 8) r.priority_req = prio_t'($urandom_range(7));
    else r.priority_req = prio_t'(255 - $urandom_range(3));
    if ($urandom_range(99) < enq_pct) begin
      r.command = spq_pkg::CMD_ENQ;
    end else begin
      case ($urandom_range(2))
        0: r.command = spq_pkg::CMD_DEQ_HEAD;
        1: begin
          r.command = spq_pkg::CMD_DEQ_EXACT;
          if ($urandom_range(3) != 0) r.priority_req = sb.stored_priority();
        end
        default: r.command = spq_pkg::CMD_DEQ_AT_MOST;
      endcase
    end
    return r;
  endfunction

  initial begin : main
    int    enq_pct;
    int    guard;
    prio_t p;
    word_t d;
    sb = new();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Dequeues of every kind on an empty queue.
    send_command(make_cmd(spq_pkg::CMD_DEQ_HEAD, 32'sd0, 8'd0));
    send_command(make_cmd(spq_pkg::CMD_DEQ_EXACT, -32'sd1, 8'd255));
    send_command(make_cmd(spq_pkg::CMD_DEQ_AT_MOST, 32'sh7fffffff, 8'd255));
    // Fill to the brim with ties at both priority extremes.
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      p = (i % 3 == 0) ? 8'd255 : (i % 3 == 1) ? 8'd0 : 8'(i * 17);
      d = (i == 0) ? 32'sh7fffffff : (i == 1) ? 32'sh80000000 : $urandom;
      send_command(make_cmd(spq_pkg::CMD_ENQ, d, p));
    end
    send_command(make_cmd(spq_pkg::CMD_ENQ, -32'sd1, 8'd7));
    send_command(make_cmd(spq_pkg::CMD_DEQ_EXACT, 32'sd0, 8'd34));
    send_command(make_cmd(spq_pkg::CMD_DEQ_EXACT, 32'sd0, 8'd1));
    send_command(make_cmd(spq_pkg::CMD_DEQ_AT_MOST, 32'sd0, 8'd0));
    send_command(make_cmd(spq_pkg::CMD_DEQ_AT_MOST, 32'sd0, 8'd255));
    send_command(make_cmd(spq_pkg::CMD_DEQ_HEAD, 32'sd0, 8'd0));

    // Random part: alternate filling and draining bursts under each idling mix.
    enq_pct = 25;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 33; recv_stall_pct = 33; end
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) enq_pct = (enq_pct == 75) ? 25 : 75;
        // The sender keeps offering while the receiver holds off.
        if (phase == 0 && k == 100) hold_requests++;
        send_command(random_command(enq_pct));
      end
    end
    req_valid <= 1'b0;

    guard = 0;
    while (sb.pending() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue_top.sv
design/spq_checker.sv
tb/testbench.sv
